>>> src/fbpu_pkg.sv
// Shared types and constants for the frame-buffer pixel unpacker.
// Used by fbpu_sequencer and framebuffer_pixel_unpacker; no dependencies.
package fbpu_pkg;

  // Depth codes held in the depth register
  localparam logic [2:0] DEPTH_1BPP  = 3'd0;
  localparam logic [2:0] DEPTH_2BPP  = 3'd1;
  localparam logic [2:0] DEPTH_4BPP  = 3'd2;
  localparam logic [2:0] DEPTH_8BPP  = 3'd3;
  localparam logic [2:0] DEPTH_16BPP = 3'd4;
  localparam logic [2:0] DEPTH_32BPP = 3'd5;
  localparam logic [2:0] DEPTH_RESET = DEPTH_8BPP;

  // Configuration register indexes
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 3;
  localparam logic [CfgIdxW-1:0] CFG_DEPTH   = 1'd0;
  localparam logic [CfgIdxW-1:0] CFG_PALETTE = 1'd1;

  // Input beat kinds
  localparam logic KIND_PIXEL   = 1'b0;
  localparam logic KIND_PALETTE = 1'b1;

  // Port widths
  localparam int unsigned InDataW  = 64;
  localparam int unsigned InUserW  = 2;
  localparam int unsigned OutDataW = 40;

  typedef struct packed {
    logic [2:0] depth_code;
    logic       palette_in_use;
  } cfg_t;

  // One pixel issued by the sequencer toward the read stage
  typedef struct packed {
    logic       valid;
    logic       last;
    logic       lookup;     // color comes from the palette read data
    logic       in_range;   // lookup index lies inside the table
    logic       is_color;
    logic [7:0] gray;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } pix_t;

endpackage

>>> src/framebuffer_pixel_unpacker.sv
// Top level of the frame-buffer pixel unpacker: configuration registers,
// palette read stage and output register. Uses fbpu_pkg, fbpu_sequencer, fbpu_palette_ram.
//
//  channel  | direction | beat contents
//  s_axis   | in        | frame byte or palette entry write
//  m_axis   | out       | one display pixel, tlast on the last pixel of a byte
//  cfg      | in        | register index and write data
//
// A byte at 1, 2, 4 or 8 bpp gives 8, 4, 2 or 1 pixel slots, one slot per cycle in
// the sequencer while the read stage advances; palette lookups read the RAM once per
// slot. 16 and 32 bpp bytes and palette writes take one slot each. A beat's pixels
// pass the sequencer item register, the read stage and the output register to m_axis.
// Reset clears control state and configuration only; palette entries hold
// nothing until written and need no clearing pass.
// A stalled output holds the read stage and then the sequencer; one more byte is
// still taken into an empty sequencer while the output register waits.
module framebuffer_pixel_unpacker #(
  parameter int unsigned PALETTE_ENTRIES = 256
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // data_byte[7:0], entry_index[15:8], color_red[31:16], color_green[47:32],
  // color_blue[63:48]
  input  logic [fbpu_pkg::InDataW-1:0]    s_axis_tdata_i,
  // kind[0], frame_start[1]
  input  logic [fbpu_pkg::InUserW-1:0]    s_axis_tuser_i,
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  // gray_level[7:0], red[15:8], green[23:16], blue[31:24], alpha[39:32]
  output logic [fbpu_pkg::OutDataW-1:0]   m_axis_tdata_o,
  // is_color[0]
  output logic                            m_axis_tuser_o,
  output logic                            m_axis_tlast_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [fbpu_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [fbpu_pkg::CfgDataW-1:0]   cfg_data_i
);

  localparam int unsigned AddrW = $clog2(PALETTE_ENTRIES);

  fbpu_pkg::cfg_t cfg_q, cfg_d;
  fbpu_pkg::pix_t iss, s2_q;
  logic           s2_valid_q, s2_valid_d;
  logic           out_valid_q, out_valid_d;
  logic           out_load, s2_adv_ok;
  logic           ram_we, ram_re;
  logic [AddrW-1:0] ram_waddr, ram_raddr;
  logic [23:0]    ram_wdata, ram_rdata;
  logic [7:0]     s2_red, s2_green, s2_blue;
  logic [fbpu_pkg::OutDataW-1:0] tdata_q;
  logic           tuser_q, tlast_q;

  // Configuration writes
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        fbpu_pkg::CFG_DEPTH:   cfg_d.depth_code     = cfg_data_i;
        fbpu_pkg::CFG_PALETTE: cfg_d.palette_in_use = cfg_data_i[0];
        default:               cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.depth_code     <= fbpu_pkg::DEPTH_RESET;
      cfg_q.palette_in_use <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Pipeline advance
  assign out_load  = s2_valid_q & (~out_valid_q | m_axis_tready_i);
  assign s2_adv_ok = ~s2_valid_q | out_load;

  fbpu_sequencer #(
    .PALETTE_ENTRIES(PALETTE_ENTRIES)
  ) u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .in_valid_i    (s_axis_tvalid_i),
    .in_ready_o    (s_axis_tready_o),
    .kind_i        (s_axis_tuser_i[0]),
    .frame_start_i (s_axis_tuser_i[1]),
    .data_byte_i   (s_axis_tdata_i[7:0]),
    .entry_index_i (s_axis_tdata_i[15:8]),
    .color_i       ({s_axis_tdata_i[31:24], s_axis_tdata_i[47:40], s_axis_tdata_i[63:56]}),
    .adv_i         (s2_adv_ok),
    .pix_o         (iss),
    .ram_we_o      (ram_we),
    .ram_waddr_o   (ram_waddr),
    .ram_wdata_o   (ram_wdata),
    .ram_re_o      (ram_re),
    .ram_raddr_o   (ram_raddr)
  );

  fbpu_palette_ram #(
    .Depth(PALETTE_ENTRIES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Read stage: pixel info waits here alongside the palette read data
  assign s2_valid_d = s2_adv_ok ? iss.valid : s2_valid_q;

  always_ff @(posedge clk_i) begin
    if (s2_adv_ok && iss.valid) begin
      s2_q <= iss;
    end
  end

  always_comb begin
    s2_red   = s2_q.red;
    s2_green = s2_q.green;
    s2_blue  = s2_q.blue;
    if (s2_q.lookup) begin
      s2_red   = s2_q.in_range ? ram_rdata[23:16] : 8'd0;
      s2_green = s2_q.in_range ? ram_rdata[15:8]  : 8'd0;
      s2_blue  = s2_q.in_range ? ram_rdata[7:0]   : 8'd0;
    end
  end

  // Output register
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s2_valid_q  <= s2_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      tdata_q <= {s2_q.alpha, s2_blue, s2_green, s2_red, s2_q.gray};
      tuser_q <= s2_q.is_color;
      tlast_q <= s2_q.last;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = tdata_q;
  assign m_axis_tuser_o  = tuser_q;
  assign m_axis_tlast_o  = tlast_q;

  // A slot either writes or reads the palette, never both
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(ram_we && ram_re))
    else $error("palette read and write in the same slot");

  // An issued pixel lands in the read stage
  assert property (@(posedge clk_i) disable iff (!rst_ni) iss.valid |=> s2_valid_q)
    else $error("issued pixel lost before the read stage");

  // Palette read data holds while the read stage is stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_valid_q && !s2_adv_ok) |=> $stable(ram_rdata))
    else $error("palette read data changed under a stall");

  // No pixel issues into a full, stalled read stage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_valid_q && !out_load) |-> !iss.valid)
    else $error("pixel issued into a stalled read stage");

endmodule

>>> src/fbpu_palette_ram.sv
// Palette storage: one write port, one registered read port, 24-bit RGB entries.
// Stand-alone; no package dependency.
module fbpu_palette_ram #(
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [23:0]              wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [23:0]              rdata_o
);

  logic [23:0] mem_q [Depth];
  logic [23:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/fbpu_sequencer.sv
// Item register and pixel sequencer: walks one byte into pixels, one per slot,
// keeps the multi-byte pixel phase and drives the palette RAM ports. Uses fbpu_pkg.
module fbpu_sequencer #(
  parameter int unsigned PALETTE_ENTRIES = 256
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  fbpu_pkg::cfg_t                     cfg_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic                               kind_i,
  input  logic                               frame_start_i,
  input  logic [7:0]                         data_byte_i,
  input  logic [7:0]                         entry_index_i,
  input  logic [23:0]                        color_i,
  input  logic                               adv_i,
  output fbpu_pkg::pix_t                     pix_o,
  output logic                               ram_we_o,
  output logic [$clog2(PALETTE_ENTRIES)-1:0] ram_waddr_o,
  output logic [23:0]                        ram_wdata_o,
  output logic                               ram_re_o,
  output logic [$clog2(PALETTE_ENTRIES)-1:0] ram_raddr_o
);

  localparam int unsigned AddrW = $clog2(PALETTE_ENTRIES);

  logic        s1_valid_q, s1_valid_d;
  logic        kind_q, fs_q;
  logic [7:0]  sh_q, sh_d;
  logic [7:0]  idx_q;
  logic [23:0] rgb_q;
  logic [3:0]  rem_q, rem_d;
  logic [1:0]  phase_q, phase_d;
  logic [23:0] held_q, held_d;

  logic        issue, step_last, accept;
  logic [1:0]  eff_phase;
  logic [23:0] eff_held;
  logic [7:0]  pix_val;
  logic [7:0]  gray_val;
  logic        val_in_range, idx_in_range;
  logic [4:0]  r5, g5, b5;

  assign step_last  = (rem_q == 4'd1);
  assign issue      = s1_valid_q & adv_i;
  assign in_ready_o = ~s1_valid_q | (issue & step_last);
  assign accept     = in_valid_i & in_ready_o;

  // frame start clears the phase before the byte is used
  assign eff_phase = fs_q ? 2'd0 : phase_q;
  assign eff_held  = fs_q ? 24'd0 : held_q;

  // Top bits of the shift register give the current pixel, MSB first
  always_comb begin
    unique case (cfg_i.depth_code)
      fbpu_pkg::DEPTH_1BPP: begin
        pix_val  = {7'd0, sh_q[7]};
        gray_val = {8{~sh_q[7]}};
      end
      fbpu_pkg::DEPTH_2BPP: begin
        pix_val  = {6'd0, sh_q[7:6]};
        gray_val = {4{~sh_q[7:6]}};
      end
      fbpu_pkg::DEPTH_4BPP: begin
        pix_val  = {4'd0, sh_q[7:4]};
        gray_val = {2{~sh_q[7:4]}};
      end
      default: begin
        pix_val  = sh_q;
        gray_val = ~sh_q;
      end
    endcase
  end

  assign val_in_range = ({1'b0, pix_val} < 9'(PALETTE_ENTRIES));
  assign idx_in_range = ({1'b0, idx_q} < 9'(PALETTE_ENTRIES));

  // ARGB1555 fields from held high byte and current low byte
  assign r5 = eff_held[6:2];
  assign g5 = {eff_held[1:0], sh_q[7:5]};
  assign b5 = sh_q[4:0];

  always_comb begin
    pix_o       = '0;
    phase_d     = phase_q;
    held_d      = held_q;
    ram_we_o    = 1'b0;
    ram_re_o    = 1'b0;
    ram_waddr_o = idx_q[AddrW-1:0];
    ram_wdata_o = rgb_q;
    ram_raddr_o = pix_val[AddrW-1:0];
    if (issue) begin
      if (kind_q == fbpu_pkg::KIND_PALETTE) begin
        ram_we_o = idx_in_range;
      end else begin
        pix_o.last = step_last;
        unique case (cfg_i.depth_code)
          fbpu_pkg::DEPTH_1BPP, fbpu_pkg::DEPTH_2BPP,
          fbpu_pkg::DEPTH_4BPP, fbpu_pkg::DEPTH_8BPP: begin
            phase_d     = 2'd0;
            held_d      = 24'd0;
            pix_o.valid = 1'b1;
            if (cfg_i.palette_in_use) begin
              ram_re_o       = val_in_range;
              pix_o.lookup   = 1'b1;
              pix_o.in_range = val_in_range;
              pix_o.is_color = 1'b1;
              pix_o.alpha    = 8'hFF;
            end else begin
              pix_o.gray = gray_val;
            end
          end
          fbpu_pkg::DEPTH_16BPP: begin
            if (eff_phase == 2'd0) begin
              held_d  = {16'd0, sh_q};
              phase_d = 2'd1;
            end else begin
              pix_o.valid    = 1'b1;
              pix_o.is_color = 1'b1;
              pix_o.red      = {r5, r5[4:2]};
              pix_o.green    = {g5, g5[4:2]};
              pix_o.blue     = {b5, b5[4:2]};
              pix_o.alpha    = {8{eff_held[7]}};
              phase_d        = 2'd0;
              held_d         = 24'd0;
            end
          end
          fbpu_pkg::DEPTH_32BPP: begin
            if (eff_phase != 2'd3) begin
              held_d  = {eff_held[15:0], sh_q};
              phase_d = eff_phase + 2'd1;
            end else begin
              pix_o.valid    = 1'b1;
              pix_o.is_color = 1'b1;
              pix_o.red      = eff_held[15:8];
              pix_o.green    = eff_held[7:0];
              pix_o.blue     = sh_q;
              pix_o.alpha    = eff_held[23:16];
              phase_d        = 2'd0;
              held_d         = 24'd0;
            end
          end
          default: begin
            // undefined depth: drop the byte
            phase_d = 2'd0;
            held_d  = 24'd0;
          end
        endcase
      end
    end
  end

  // Item register: load on accept, otherwise shift to the next pixel on each issued slot
  always_comb begin
    s1_valid_d = s1_valid_q;
    sh_d       = sh_q;
    rem_d      = rem_q;
    if (accept) begin
      s1_valid_d = 1'b1;
      sh_d       = data_byte_i;
      if (kind_i == fbpu_pkg::KIND_PIXEL && cfg_i.depth_code <= fbpu_pkg::DEPTH_8BPP) begin
        rem_d = 4'd8 >> cfg_i.depth_code[1:0];
      end else begin
        rem_d = 4'd1;
      end
    end else if (issue) begin
      if (step_last) begin
        s1_valid_d = 1'b0;
      end else begin
        rem_d = rem_q - 4'd1;
        unique case (cfg_i.depth_code)
          fbpu_pkg::DEPTH_1BPP: sh_d = {sh_q[6:0], 1'b0};
          fbpu_pkg::DEPTH_2BPP: sh_d = {sh_q[5:0], 2'b0};
          fbpu_pkg::DEPTH_4BPP: sh_d = {sh_q[3:0], 4'b0};
          default:              sh_d = sh_q;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      rem_q      <= 4'd0;
      phase_q    <= 2'd0;
      held_q     <= 24'd0;
    end else begin
      s1_valid_q <= s1_valid_d;
      rem_q      <= rem_d;
      phase_q    <= phase_d;
      held_q     <= held_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q <= sh_d;
    if (accept) begin
      kind_q <= kind_i;
      fs_q   <= frame_start_i;
      idx_q  <= entry_index_i;
      rgb_q  <= color_i;
    end else if (issue) begin
      // frame start applies to the first pixel slot only
      fs_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rst_ni && s1_valid_q) begin
      assert (rem_q != 4'd0)
        else $error("sequencer holds an item with no pixel slots left");
    end
  end

endmodule

>>> bench/tb_top.sv
// Self-checking bench for framebuffer_pixel_unpacker: directed rows, then random bursts.
// Every m_axis beat is compared with an expected pixel, typed in the row or from a local predictor.
// Depends on fbpu_pkg and the framebuffer_pixel_unpacker RTL.
`timescale 1ns / 100ps

module tb_top;
  import fbpu_pkg::*;

  localparam int          AUTO         = -1;   // row is checked against the predictor
  localparam int unsigned LIMIT_CYCLES = 400000;
  localparam int unsigned RAND_BEATS   = 480;
  localparam int unsigned SETTLE_CYC   = 8;

  typedef struct packed {
    logic       is_color;
    logic [7:0] gray;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       last;
  } px_t;

  typedef struct {
    logic [2:0]  depth;
    logic        pal;
    logic        keep_cfg;
    logic        kind;
    logic        fs;
    logic [63:0] d;
    int          n_typed;
    px_t         want;
  } stim_row_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid_i = 1'b0;
  logic                  s_axis_tready_o;
  logic [InDataW-1:0]    s_axis_tdata_i = '0;
  logic [InUserW-1:0]    s_axis_tuser_i = '0;
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i = 1'b0;
  logic [OutDataW-1:0]   m_axis_tdata_o;
  logic                  m_axis_tuser_o;
  logic                  m_axis_tlast_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CfgIdxW-1:0]    cfg_index_i = '0;
  logic [CfgDataW-1:0]   cfg_data_i = '0;

  // predictor state
  logic [23:0] pal_rgb [0:255];
  logic        pal_set [0:255];
  logic [1:0]  pix_phase = 2'd0;
  logic [23:0] pix_held = 24'h0;
  logic [2:0]  cur_depth = DEPTH_RESET;
  logic        pal_use = 1'b0;

  px_t         fresh_px[$];
  px_t         exp_pixels[$];
  stim_row_t   steps[$];
  int unsigned beats_sent = 0;
  int unsigned mismatches = 0;
  logic        calm = 1'b0;

  framebuffer_pixel_unpacker DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic px_t pixel(logic ic, logic [7:0] gray, logic [7:0] r, logic [7:0] g,
                                logic [7:0] b, logic [7:0] a, logic last);
    px_t p;
    p.is_color = ic;
    p.gray     = gray;
    p.red      = r;
    p.green    = g;
    p.blue     = b;
    p.alpha    = a;
    p.last     = last;
    return p;
  endfunction

  function automatic logic [7:0] widen5(logic [4:0] c5);
    return {c5, c5[4:2]};
  endfunction

  // Index or value of the i-th pixel in a byte, MSB first
  function automatic logic [7:0] field_at(logic [7:0] b8, logic [2:0] depth, int i);
    int bits;
    bits = 1 << depth;
    return 8'((b8 >> (8 - bits * (i + 1))) & ((1 << bits) - 1));
  endfunction

  // Pixels caused by one accepted beat; leaves them in fresh_px
  function automatic void unpack_beat(logic kind, logic fs, logic [63:0] d);
    logic [7:0]  byte_v;
    logic [7:0]  v;
    logic [7:0]  g;
    logic [7:0]  hi;
    logic [23:0] e;
    px_t         tail;
    int          i;
    fresh_px.delete();
    byte_v = d[7:0];
    if (kind == KIND_PALETTE) begin
      // keep the top byte of each 16-bit component
      pal_rgb[d[15:8]] = {d[31:24], d[47:40], d[63:56]};
      pal_set[d[15:8]] = 1'b1;
      return;
    end
    if (fs) begin
      pix_phase = 2'd0;
      pix_held  = 24'h0;
    end
    if (cur_depth <= DEPTH_8BPP) begin
      pix_phase = 2'd0;
      pix_held  = 24'h0;
      for (i = 0; i < (8 >> cur_depth); i++) begin
        v = field_at(byte_v, cur_depth, i);
        if (pal_use) begin
          e = pal_rgb[v];
          fresh_px.push_back(pixel(1'b1, 8'h00, e[23:16], e[15:8], e[7:0], 8'hFF, 1'b0));
        end else begin
          case (cur_depth)
            DEPTH_1BPP: g = v[0] ? 8'h00 : 8'hFF;
            DEPTH_2BPP: g = 8'hFF - 8'h55 * v;
            DEPTH_4BPP: g = 8'hFF - 8'h11 * v;
            default:    g = ~v;
          endcase
          fresh_px.push_back(pixel(1'b0, g, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0));
        end
      end
    end else if (cur_depth == DEPTH_16BPP) begin
      if (pix_phase == 2'd0) begin
        pix_held  = {16'h0, byte_v};
        pix_phase = 2'd1;
      end else begin
        // any nonzero phase completes the pixel; the newest held byte is the high one
        hi = pix_held[7:0];
        fresh_px.push_back(pixel(1'b1, 8'h00, widen5(hi[6:2]), widen5({hi[1:0], byte_v[7:5]}),
                                 widen5(byte_v[4:0]), hi[7] ? 8'hFF : 8'h00, 1'b0));
        pix_phase = 2'd0;
        pix_held  = 24'h0;
      end
    end else if (cur_depth == DEPTH_32BPP) begin
      if (pix_phase != 2'd3) begin
        pix_held  = {pix_held[15:0], byte_v};
        pix_phase = pix_phase + 2'd1;
      end else begin
        fresh_px.push_back(pixel(1'b1, 8'h00, pix_held[15:8], pix_held[7:0], byte_v,
                                 pix_held[23:16], 1'b0));
        pix_phase = 2'd0;
        pix_held  = 24'h0;
      end
    end else begin
      pix_phase = 2'd0;
      pix_held  = 24'h0;
    end
    if (fresh_px.size() != 0) begin
      tail = fresh_px.pop_back();
      tail.last = 1'b1;
      fresh_px.push_back(tail);
    end
  endfunction

  function automatic void pix_row(logic [2:0] depth, logic pal, logic fs, logic [7:0] byte_v,
                                  int n_typed, px_t want);
    stim_row_t row;
    row.depth    = depth;
    row.pal      = pal;
    row.keep_cfg = 1'b0;
    row.kind     = KIND_PIXEL;
    row.fs       = fs;
    row.d        = {56'h0, byte_v};
    row.n_typed  = n_typed;
    row.want     = want;
    steps.push_back(row);
  endfunction

  function automatic void pal_row(logic fs, logic [7:0] idx, logic [15:0] r, logic [15:0] g,
                                  logic [15:0] b);
    stim_row_t row;
    row.depth    = DEPTH_RESET;
    row.pal      = 1'b0;
    row.keep_cfg = 1'b1;
    row.kind     = KIND_PALETTE;
    row.fs       = fs;
    row.d        = {b, g, r, idx, 8'h5A};
    row.n_typed  = 0;
    row.want     = '0;
    steps.push_back(row);
  endfunction

  task automatic drive_beat(logic kind, logic fs, logic [63:0] d);
    while (!calm && $urandom_range(99) < 13) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= d;
    s_axis_tuser_i  <= {fs, kind};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    if (kind == KIND_PALETTE || cur_depth <= DEPTH_32BPP) beats_sent++;
    unpack_beat(kind, fs, d);
  endtask

  task automatic send_item(logic kind, logic fs, logic [63:0] d, int n_typed, px_t want);
    logic [7:0]  v;
    logic [63:0] fill;
    int          i;
    // load any palette entry this byte looks up that has never been written
    if (kind == KIND_PIXEL && pal_use && cur_depth <= DEPTH_8BPP) begin
      for (i = 0; i < (8 >> cur_depth); i++) begin
        v = field_at(d[7:0], cur_depth, i);
        if (!pal_set[v]) begin
          fill = {$urandom, $urandom};
          fill[15:8] = v;
          drive_beat(KIND_PALETTE, 1'($urandom_range(1, 0)), fill);
        end
      end
    end
    drive_beat(kind, fs, d);
    if (n_typed == AUTO) begin
      foreach (fresh_px[k]) exp_pixels.push_back(fresh_px[k]);
    end else if (n_typed == 1) begin
      exp_pixels.push_back(want);
    end
  endtask

  task automatic settle();
    s_axis_tvalid_i <= 1'b0;
    while (exp_pixels.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  task automatic write_cfg(logic [2:0] depth, logic pal);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= CFG_DEPTH;
    cfg_data_i  <= depth;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cur_depth   = depth;
    cfg_index_i <= CFG_PALETTE;
    cfg_data_i  <= {2'b00, pal};
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    pal_use     = pal;
    cfg_valid_i <= 1'b0;
  endtask

  // output side: random stalls except during the calm stretch
  always @(posedge clk_i) begin
    m_axis_tready_i <= calm || ($urandom_range(99) >= 13);
  end

  always @(posedge clk_i) begin : pixel_check
    px_t got;
    px_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got = pixel(m_axis_tuser_o, m_axis_tdata_o[7:0], m_axis_tdata_o[15:8],
                  m_axis_tdata_o[23:16], m_axis_tdata_o[31:24], m_axis_tdata_o[39:32],
                  m_axis_tlast_o);
      if (exp_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected pixel c=%0b g=%h rgba=%h_%h_%h_%h l=%0b", $time,
                   got.is_color, got.gray, got.red, got.green, got.blue, got.alpha, got.last);
      end else begin
        want = exp_pixels.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: pixel mismatch, expected c=%0b g=%h rgba=%h_%h_%h_%h l=%0b",
                     $time, want.is_color, want.gray, want.red, want.green, want.blue,
                     want.alpha, want.last);
            $display("%0t:                 actual   c=%0b g=%h rgba=%h_%h_%h_%h l=%0b",
                     $time, got.is_color, got.gray, got.red, got.green, got.blue,
                     got.alpha, got.last);
          end
        end
      end
    end
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < LIMIT_CYCLES) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("%0t: run timed out", $time);
    $display("** framebuffer_pixel_unpacker: FAILED **");
    $finish;
  end

  initial begin : stimulus
    int unsigned rand_base;
    int unsigned phase_no;
    int unsigned burst;
    logic [2:0]  new_depth;
    logic        new_pal;
    logic        fs;
    logic [63:0] d;
    px_t         none;

    none = '0;
    foreach (pal_set[k]) pal_set[k] = 1'b0;

    // after reset: 8 bpp gray
    pix_row(DEPTH_8BPP, 1'b0, 1'b1, 8'h00, 1, pixel(1'b0, 8'hFF, 0, 0, 0, 0, 1'b1));
    pix_row(DEPTH_8BPP, 1'b0, 1'b0, 8'hFF, 1, pixel(1'b0, 8'h00, 0, 0, 0, 0, 1'b1));
    pix_row(DEPTH_1BPP, 1'b0, 1'b0, 8'hA5, AUTO, none);
    pix_row(DEPTH_2BPP, 1'b0, 1'b0, 8'h1B, AUTO, none);
    pix_row(DEPTH_4BPP, 1'b0, 1'b1, 8'hF0, AUTO, none);
    pal_row(1'b1, 8'h00, 16'hFFFF, 16'h0000, 16'h8000);
    pal_row(1'b0, 8'h01, 16'h00FF, 16'hFF00, 16'h0F0F);
    pal_row(1'b0, 8'h02, 16'h8080, 16'h4040, 16'h2020);
    pal_row(1'b0, 8'h03, 16'h1234, 16'h5678, 16'h9ABC);
    pal_row(1'b0, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    pix_row(DEPTH_8BPP, 1'b1, 1'b0, 8'hFF, 1, pixel(1'b1, 0, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1));
    pix_row(DEPTH_1BPP, 1'b1, 1'b0, 8'h80, AUTO, none);
    pix_row(DEPTH_2BPP, 1'b1, 1'b1, 8'hE4, AUTO, none);
    // 16 bpp: white, then pure red with alpha clear
    pix_row(DEPTH_16BPP, 1'b1, 1'b1, 8'hFF, 0, none);
    pix_row(DEPTH_16BPP, 1'b1, 1'b0, 8'hFF, 1, pixel(1'b1, 0, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1));
    pix_row(DEPTH_16BPP, 1'b0, 1'b0, 8'h7C, 0, none);
    pix_row(DEPTH_16BPP, 1'b0, 1'b0, 8'h00, 1, pixel(1'b1, 0, 8'hFF, 8'h00, 8'h00, 8'h00, 1'b1));
    // 32 bpp: frame start in the middle of a pixel restarts it
    pix_row(DEPTH_32BPP, 1'b0, 1'b0, 8'h99, 0, none);
    pix_row(DEPTH_32BPP, 1'b0, 1'b1, 8'h11, 0, none);
    pix_row(DEPTH_32BPP, 1'b0, 1'b0, 8'h22, 0, none);
    pix_row(DEPTH_32BPP, 1'b0, 1'b0, 8'h33, 0, none);
    pix_row(DEPTH_32BPP, 1'b0, 1'b0, 8'h44, 1, pixel(1'b1, 0, 8'h22, 8'h33, 8'h44, 8'h11, 1'b1));
    // one byte of a 32 bpp pixel, a palette write that must not touch the phase,
    // then 16 bpp takes the next byte as the low byte
    pix_row(DEPTH_32BPP, 1'b0, 1'b0, 8'hAA, 0, none);
    pal_row(1'b1, 8'h04, 16'hC3C3, 16'h3C3C, 16'h0101);
    pix_row(DEPTH_16BPP, 1'b0, 1'b0, 8'hCC, AUTO, none);
    // undefined depths drop the byte
    pix_row(3'd6, 1'b0, 1'b0, 8'h5A, 0, none);
    pix_row(3'd7, 1'b1, 1'b1, 8'hA5, 0, none);

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (steps[k]) begin
      if (!steps[k].keep_cfg && (steps[k].depth != cur_depth || steps[k].pal != pal_use)) begin
        settle();
        write_cfg(steps[k].depth, steps[k].pal);
      end
      send_item(steps[k].kind, steps[k].fs, steps[k].d, steps[k].n_typed, steps[k].want);
    end

    rand_base = beats_sent;
    phase_no  = 0;
    while (beats_sent - rand_base < RAND_BEATS) begin
      settle();
      if ($urandom_range(99) < 8) new_depth = 3'($urandom_range(7, 6));
      else new_depth = 3'($urandom_range(5, 0));
      new_pal = 1'($urandom_range(1, 0));
      write_cfg(new_depth, new_pal);
      calm  = (phase_no >= 4 && phase_no < 8);
      burst = $urandom_range(40, 8);
      repeat (burst) begin
        d = {$urandom, $urandom};
        if ($urandom_range(99) < 10) begin
          send_item(KIND_PALETTE, 1'($urandom_range(1, 0)), d, AUTO, none);
        end else begin
          // multi-byte pixels: frame start mostly on a pixel boundary, rarely anywhere
          if (cur_depth == DEPTH_16BPP || cur_depth == DEPTH_32BPP)
            fs = (pix_phase == 2'd0 && $urandom_range(99) < 30) || $urandom_range(99) < 3;
          else
            fs = 1'($urandom_range(1, 0));
          send_item(KIND_PIXEL, fs, d, AUTO, none);
        end
      end
      phase_no++;
    end
    calm = 1'b0;

    settle();
    if (mismatches == 0 && exp_pixels.size() == 0)
      $display("** framebuffer_pixel_unpacker: PASSED **");
    else
      $display("** framebuffer_pixel_unpacker: FAILED **");
    $finish;
  end

endmodule
